### hw/rtl/vcp_pkg.sv
// voice channel picker: shared types, codes and constants
// depends on nothing; used by the interface users, the table, the picker and the top level
package vcp_pkg;

    localparam int ENTITY_W  = 10;
    localparam int ECHAN_W   = 8;
    localparam int LEN_W     = 24;
    localparam int STEP_W    = 16;
    localparam int SEL_W     = 5;
    localparam int TIME_W    = 32;
    localparam int IDX_OUT_W = 5;

    // largest signed remaining life; a channel at this life is never taken as the least-life pick
    localparam logic [TIME_W-1:0] LIFE_LIMIT = 32'h7fff_ffff;

    typedef enum logic [1:0] {
        FUNC_START   = 2'd0,
        FUNC_ADVANCE = 2'd1,
        FUNC_MARK    = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REASON_NONE     = 2'd0,
        REASON_OVERRIDE = 2'd1,
        REASON_LEAST    = 2'd2
    } reason_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RESP
    } state_t;

    typedef struct packed {
        func_t              func;
        logic [ENTITY_W-1:0] entity_number;
        logic [ECHAN_W-1:0]  entity_channel;
        logic [LEN_W-1:0]    sound_length;
        logic [STEP_W-1:0]   time_step;
        logic [SEL_W-1:0]    channel_select;
        logic                mark_value;
    } req_t;

    typedef struct packed {
        logic                 found;
        logic [IDX_OUT_W-1:0] channel_index;
        reason_t              pick_reason;
    } rsp_t;

    typedef logic [ENTITY_W-1:0] cfg_t;

    // one voice table entry as stored in memory
    typedef struct packed {
        logic [ENTITY_W-1:0] entity;
        logic [ECHAN_W-1:0]  entity_channel;
        logic [TIME_W-1:0]   end_time;
        logic                busy;
    } entry_t;

    // control from the sequencer to the picker
    typedef struct packed {
        logic clear;
        logic eval;
    } pick_ctl_t;

    // status from the picker back to the sequencer
    typedef struct packed {
        logic    found;
        logic    override_hit;
        reason_t reason;
    } pick_status_t;

endpackage

### hw/rtl/vcp_chan_if.sv
// valid/ready channel carrying one payload beat
// payload type is a parameter; no other dependencies
interface vcp_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/vcp_table.sv
// voice table storage: entry memory with registered read, per-entry valid and streaming bits
// depends on vcp_pkg
module vcp_table #(
    parameter int NUM_CHANNELS = 32,
    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output vcp_pkg::entry_t rd_entry,
    output logic            rd_streaming,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  vcp_pkg::entry_t wr_entry,
    input  logic            mark_en,
    input  logic [AW-1:0]   mark_addr,
    input  logic            mark_value,
    input  logic            clear_all
);
    import vcp_pkg::*;

    entry_t                  mem [NUM_CHANNELS];
    entry_t                  rd_data_reg;
    logic                    rd_valid_reg;
    logic                    rd_stream_reg;
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic [NUM_CHANNELS-1:0] stream_reg;

    // entry memory, one write and one read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // valid and streaming bits; an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            stream_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            rd_stream_reg <= 1'b0;
        end
        else
        begin
            if (clear_all)
            begin
                valid_reg  <= '0;
                stream_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr]  <= 1'b1;
                stream_reg[wr_addr] <= 1'b0;
            end
            else if (mark_en)
            begin
                stream_reg[mark_addr] <= mark_value;
            end
            if (rd_en)
            begin
                rd_valid_reg  <= valid_reg[rd_addr];
                rd_stream_reg <= stream_reg[rd_addr];
            end
        end
    end

    assign rd_entry     = rd_valid_reg ? rd_data_reg : '0;
    assign rd_streaming = rd_stream_reg;

endmodule

### hw/rtl/vcp_pick.sv
// channel picker: judges one table entry per beat and tracks the best candidate
// depends on vcp_pkg
module vcp_pick #(
    parameter int NUM_CHANNELS = 32,
    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  vcp_pkg::pick_ctl_t             ctl,
    input  logic [AW-1:0]                  idx,
    input  vcp_pkg::entry_t                entry,
    input  logic                           streaming,
    input  logic [vcp_pkg::ENTITY_W-1:0]   req_entity,
    input  logic [vcp_pkg::ECHAN_W-1:0]    req_echan,
    input  logic [vcp_pkg::ENTITY_W-1:0]   player_entity,
    input  logic [vcp_pkg::TIME_W-1:0]     painted_time,
    output vcp_pkg::pick_status_t          status,
    output logic [AW-1:0]                  pick_idx
);
    import vcp_pkg::*;

    logic [TIME_W-1:0] best_reg, best_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              found_reg, found_next;
    logic              over_reg, over_next;
    logic [TIME_W-1:0] life;
    logic              is_over;
    logic              is_prot;
    logic              is_less;

    // per-entry tests
    always_comb
    begin
        life    = entry.end_time - painted_time;
        is_over = (req_echan != '0) && (entry.entity == req_entity)
                  && (entry.entity_channel == req_echan);
        is_prot = (entry.entity == player_entity) && (req_entity != player_entity)
                  && entry.busy;
        is_less = $signed(life) < $signed(best_reg);
    end

    // candidate update; nothing but a clear changes once an override hit is held
    always_comb
    begin
        best_next  = best_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        over_next  = over_reg;
        if (ctl.clear)
        begin
            best_next  = LIFE_LIMIT;
            idx_next   = '0;
            found_next = 1'b0;
            over_next  = 1'b0;
        end
        else if (ctl.eval && !over_reg && !streaming)
        begin
            if (is_over)
            begin
                idx_next   = idx;
                found_next = 1'b1;
                over_next  = 1'b1;
            end
            else if (!is_prot && is_less)
            begin
                best_next  = life;
                idx_next   = idx;
                found_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            over_reg  <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
            over_reg  <= over_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        idx_reg  <= idx_next;
    end

    assign status.found        = found_reg;
    assign status.override_hit = over_reg;
    assign status.reason       = over_reg  ? REASON_OVERRIDE :
                                 found_reg ? REASON_LEAST : REASON_NONE;
    assign pick_idx            = idx_reg;

endmodule

### hw/rtl/voice_channel_picker_unit.sv
// voice channel picker top level: request sequencer, painted time, player register
// depends on vcp_pkg, vcp_chan_if, vcp_table and vcp_pick
//
// A start request reads the voice table one channel per cycle through the single
// read port of the entry memory, stopping early when a same-entity override is
// found; the chosen channel is written back after the scan. Advance, streaming
// mark and clear requests take effect in the cycle they are accepted and pass
// their result through the response state to the output register. One request is
// in flight at a time; the next request is taken as soon as the result sits in the
// output register. The player entity register resets to 1 and may be written only
// while no request is open.
module voice_channel_picker_unit #(
    parameter int NUM_CHANNELS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    vcp_chan_if.sink   req,
    vcp_chan_if.source rsp,
    vcp_chan_if.sink   cfg
);
    import vcp_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CW = $clog2(NUM_CHANNELS + 1);
    localparam logic [CW-1:0] CNT_END = CW'(NUM_CHANNELS);

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                eval_vld_reg;
    logic [AW-1:0]       eval_idx_reg;
    req_t                req_reg;
    logic [TIME_W-1:0]   painted_reg, painted_next;
    logic [ENTITY_W-1:0] player_reg;
    rsp_t                res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    rsp_t                out_data_reg;
    logic                out_load;

    logic                req_acc;
    logic                rd_en;
    logic                wr_en;
    logic                mark_en;
    logic                clear_all;
    entry_t              rd_entry;
    entry_t              wr_entry;
    logic                rd_streaming;
    pick_ctl_t           pick_ctl;
    pick_status_t        pick_status;
    logic [AW-1:0]       pick_idx;

    vcp_table #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (rd_en),
        .rd_addr     (cnt_reg[AW-1:0]),
        .rd_entry    (rd_entry),
        .rd_streaming(rd_streaming),
        .wr_en       (wr_en),
        .wr_addr     (pick_idx),
        .wr_entry    (wr_entry),
        .mark_en     (mark_en),
        .mark_addr   (AW'(req.data.channel_select)),
        .mark_value  (req.data.mark_value),
        .clear_all   (clear_all)
    );

    vcp_pick #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_pick (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (pick_ctl),
        .idx          (eval_idx_reg),
        .entry        (rd_entry),
        .streaming    (rd_streaming),
        .req_entity   (req_reg.entity_number),
        .req_echan    (req_reg.entity_channel),
        .player_entity(player_reg),
        .painted_time (painted_reg),
        .status       (pick_status),
        .pick_idx     (pick_idx)
    );

    // new entry for the chosen channel
    always_comb
    begin
        wr_entry.entity         = req_reg.entity_number;
        wr_entry.entity_channel = req_reg.entity_channel;
        wr_entry.end_time       = painted_reg + TIME_W'(req_reg.sound_length);
        wr_entry.busy           = 1'b1;
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // sequencer: next state and strobes
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        painted_next   = painted_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        mark_en        = 1'b0;
        clear_all      = 1'b0;
        pick_ctl.clear = 1'b0;
        pick_ctl.eval  = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    res_next = '0;
                    unique case (req.data.func)
                        FUNC_START:
                        begin
                            pick_ctl.clear = 1'b1;
                            cnt_next       = '0;
                            state_next     = ST_SCAN;
                        end
                        FUNC_ADVANCE:
                        begin
                            painted_next = painted_reg + TIME_W'(req.data.time_step);
                            state_next   = ST_RESP;
                        end
                        FUNC_MARK:
                        begin
                            mark_en    = (32'(req.data.channel_select) < NUM_CHANNELS);
                            state_next = ST_RESP;
                        end
                        FUNC_CLEAR:
                        begin
                            clear_all  = 1'b1;
                            state_next = ST_RESP;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                pick_ctl.eval = eval_vld_reg;
                if (pick_status.override_hit || (cnt_reg == CNT_END && !eval_vld_reg))
                begin
                    state_next = ST_WRITE;
                end
                else if (cnt_reg != CNT_END)
                begin
                    rd_en    = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_WRITE:
            begin
                wr_en = pick_status.found;
                if (pick_status.found)
                begin
                    res_next.found         = 1'b1;
                    res_next.channel_index = IDX_OUT_W'(pick_idx);
                    res_next.pick_reason   = pick_status.reason;
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            eval_vld_reg  <= 1'b0;
            painted_reg   <= '0;
            player_reg    <= ENTITY_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            eval_vld_reg  <= rd_en;
            painted_reg   <= painted_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                player_reg <= cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        eval_idx_reg <= cnt_reg[AW-1:0];
        res_reg      <= res_next;
        if (req_acc)
        begin
            req_reg <= req.data;
        end
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

`ifndef SYNTHESIS
    // a held result never claims a channel without a reason
    a_found_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.found) |->
        (out_data_reg.pick_reason == REASON_OVERRIDE
         || out_data_reg.pick_reason == REASON_LEAST))
        else $error("found result without a pick reason");

    // an empty result is all zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.found) |->
        (out_data_reg.channel_index == '0 && out_data_reg.pick_reason == REASON_NONE))
        else $error("empty result carries a channel or reason");

    // an accepted request always leaves idle on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> (state_reg != ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // the scan counter never runs past the table
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= CNT_END))
        else $error("scan counter past end of table");

    // the table is written only right after a scan that found a channel
    a_write_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ($past(state_reg) == ST_SCAN && pick_status.found))
        else $error("table write outside a completed scan");
`endif

endmodule
